// ===== design/icaf_pkg.sv =====
// Shared types, constants and lookup tables of the IMU attitude filter.
`default_nettype none
package icaf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int VEC_STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W = $clog2(ATAN_ENTRIES);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VEC_STEPS - 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_FS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Z  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP    = 3'd6;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_angle;
        logic signed [31:0] yaw_angle;
    } out_t;

    typedef struct packed {
        logic [1:0]         accel_fs;
        logic [1:0]         gyro_fs;
        logic signed [27:0] gyro_bias_x;
        logic signed [27:0] gyro_bias_y;
        logic signed [27:0] gyro_bias_z;
        logic [15:0]        blend_weight;
        logic [15:0]        rate_step;
    } cfg_t;

    typedef struct packed {
        logic valid;
        in_t  item;
    } fq_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GMUL,
        ST_GSTEP,
        ST_VINIT,
        ST_VEC1,
        ST_MAG,
        ST_VEC2,
        ST_BMUL,
        ST_BSUM,
        ST_DONE
    } state_t;

    // arctangent of 2^-i in Q16.16 degrees
    function automatic logic [22:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [22:0] v;
        unique case (i)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // round(2^32 / LSB-per-deg/s)
    function automatic logic [27:0] gyro_recip(input logic [1:0] code);
        logic [27:0] v;
        unique case (code)
            2'd0: v = 28'd32786009;
            2'd1: v = 28'd65572019;
            2'd2: v = 28'd130944637;
            default: v = 28'd261889274;
        endcase
        return v;
    endfunction

    // 0.001 g in raw LSB * 256
    function automatic logic [12:0] tilt_floor(input logic [1:0] code);
        logic [12:0] v;
        unique case (code)
            2'd0: v = 13'd4194;
            2'd1: v = 13'd2097;
            2'd2: v = 13'd1049;
            default: v = 13'd524;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== design/icaf_front.sv =====
// Front end: two-beat sample queue between the input port and the sequencer.
`default_nettype none
module icaf_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire icaf_pkg::in_t sample,
    input  wire logic         deq,
    output icaf_pkg::fq_t     head
);
    import icaf_pkg::*;

    in_t        mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full       = (cnt_reg == 2'd2);
    assign do_wr      = push && !full;
    assign do_rd      = deq && (cnt_reg != 2'd0);
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= sample;
    end

endmodule
`default_nettype wire

// ===== design/icaf_back.sv =====
// Back end: sequencer for gyro scaling, CORDIC tilt, blending and result register.
`default_nettype none
module icaf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire icaf_pkg::cfg_t cfg,
    input  wire icaf_pkg::fq_t  head,
    output logic                deq,
    input  wire logic           pop,
    output logic                empty,
    output icaf_pkg::out_t      result
);
    import icaf_pkg::*;

    state_t state_reg, state_next;
    logic   out_load;

    in_t                item_reg;
    logic [1:0]         ax_reg;
    logic               pass_reg;
    logic [STEP_W-1:0]  i_reg;
    logic signed [29:0] t_reg;
    logic signed [30:0] dx_reg, dy_reg, dz_reg;
    logic signed [26:0] x_reg, y_reg;
    logic signed [24:0] z_reg;
    logic signed [24:0] pacc_reg, racc_reg;
    logic signed [49:0] bm_reg;
    logic signed [31:0] pitch_reg, roll_reg, yaw_reg;
    out_t               out_reg;
    logic               out_valid_reg;

    // gyro datapath
    logic signed [15:0] raw_sel;
    logic signed [27:0] bias_sel;
    logic signed [44:0] gp, gpr;
    logic signed [46:0] sp, spr;
    // CORDIC datapath
    logic signed [15:0] a_sel, b_sel, num_sel;
    logic signed [16:0] a_abs, b_abs;
    logic signed [26:0] xs, ys, x_step, y_step;
    logic signed [24:0] z_step, atan_v;
    logic signed [43:0] mp, mpr;
    logic signed [27:0] mag, mag_fl;
    // blend datapath
    logic signed [31:0] est_sel;
    logic signed [30:0] d_sel;
    logic signed [24:0] acc_sel;
    logic signed [32:0] diff;
    logic signed [17:0] beta;
    logic signed [42:0] accb;
    logic signed [50:0] bsum;
    logic signed [34:0] brnd;
    logic signed [31:0] bsat;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (head.valid) state_next = ST_GMUL;
            ST_GMUL:  state_next = ST_GSTEP;
            ST_GSTEP: state_next = (ax_reg == 2'd2) ? ST_VINIT : ST_GMUL;
            ST_VINIT: state_next = ST_VEC1;
            ST_VEC1:  if (i_reg == STEP_LAST) state_next = ST_MAG;
            ST_MAG:   state_next = ST_VEC2;
            ST_VEC2:  if (i_reg == STEP_LAST) state_next = pass_reg ? ST_BMUL : ST_VINIT;
            ST_BMUL:  state_next = ST_BSUM;
            ST_BSUM:  state_next = pass_reg ? ST_DONE : ST_BMUL;
            ST_DONE:  if (!out_valid_reg || pop) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        deq      = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: deq = head.valid;
            ST_DONE: out_load = !out_valid_reg || pop;
            default: ;
        endcase
    end

    // gyro: G = rnd16(raw*k) - bias, D = rnd16(G*step)
    always_comb
    begin
        case (ax_reg)
            2'd0:    begin raw_sel = item_reg.rate_x; bias_sel = cfg.gyro_bias_x; end
            2'd1:    begin raw_sel = item_reg.rate_y; bias_sel = cfg.gyro_bias_y; end
            default: begin raw_sel = item_reg.rate_z; bias_sel = cfg.gyro_bias_z; end
        endcase
        gp  = raw_sel * $signed({1'b0, gyro_recip(cfg.gyro_fs)});
        gpr = gp + 45'sd32768;
        sp  = t_reg * $signed({1'b0, cfg.rate_step});
        spr = sp + 47'sd32768;
    end

    // CORDIC vectoring, one rotation per cycle
    always_comb
    begin
        if (pass_reg)
        begin
            a_sel = item_reg.accel_z; b_sel = item_reg.accel_x; num_sel = item_reg.accel_y;
        end
        else
        begin
            a_sel = item_reg.accel_x; b_sel = item_reg.accel_y; num_sel = item_reg.accel_z;
        end
        a_abs  = a_sel[15] ? -17'(a_sel) : 17'(a_sel);
        b_abs  = b_sel[15] ? -17'(b_sel) : 17'(b_sel);
        xs     = x_reg >>> i_reg;
        ys     = y_reg >>> i_reg;
        atan_v = $signed({2'b00, atan_q16(i_reg)});
        if (!y_reg[26])
        begin
            x_step = x_reg + ys; y_step = y_reg - xs; z_step = z_reg + atan_v;
        end
        else
        begin
            x_step = x_reg - ys; y_step = y_reg + xs; z_step = z_reg - atan_v;
        end
        mp     = x_reg * 17'sd39797;
        mpr    = mp + 44'sd32768;
        mag    = mpr[43:16];
        mag_fl = (mag < $signed({15'd0, tilt_floor(cfg.accel_fs)}))
                 ? $signed({15'd0, tilt_floor(cfg.accel_fs)}) : mag;
    end

    // blend: sat32(rnd16((est - D)*alpha + acc*(65536-alpha)))
    always_comb
    begin
        est_sel = pass_reg ? roll_reg : pitch_reg;
        d_sel   = pass_reg ? dz_reg : dy_reg;
        acc_sel = pass_reg ? racc_reg : pacc_reg;
        diff    = 33'(est_sel) - 33'(d_sel);
        beta    = $signed(18'd65536 - {2'b00, cfg.blend_weight});
        accb    = acc_sel * beta;
        bsum    = 51'(bm_reg) + 51'(accb) + 51'sd32768;
        brnd    = bsum[50:16];
        if (brnd > 35'sd2147483647)
            bsat = 32'sh7fffffff;
        else if (brnd < -35'sd2147483648)
            bsat = 32'sh80000000;
        else
            bsat = 32'(brnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            yaw_reg       <= '0;
            ax_reg        <= '0;
            pass_reg      <= 1'b0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    ax_reg   <= '0;
                    pass_reg <= 1'b0;
                end
                ST_GSTEP: ax_reg <= ax_reg + 2'd1;
                ST_VINIT: i_reg <= '0;
                ST_VEC1, ST_VEC2:
                begin
                    i_reg <= (i_reg == STEP_LAST) ? '0 : i_reg + 1'b1;
                    if (state_reg == ST_VEC2 && i_reg == STEP_LAST)
                        pass_reg <= !pass_reg;
                end
                ST_BSUM:
                begin
                    if (pass_reg)
                        roll_reg <= bsat;
                    else
                        pitch_reg <= bsat;
                    pass_reg <= !pass_reg;
                end
                ST_DONE:
                    if (out_load)
                        yaw_reg <= yaw_reg + 32'(dx_reg);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:  if (head.valid) item_reg <= head.item;
            ST_GMUL:  t_reg <= 30'($signed(gpr[44:16])) - 30'(bias_sel);
            ST_GSTEP:
            begin
                case (ax_reg)
                    2'd0:    dx_reg <= spr[46:16];
                    2'd1:    dy_reg <= spr[46:16];
                    default: dz_reg <= spr[46:16];
                endcase
            end
            ST_VINIT:
            begin
                x_reg <= 27'(a_abs) <<< 8;
                y_reg <= 27'(b_abs) <<< 8;
                z_reg <= '0;
            end
            ST_VEC1:
            begin
                x_reg <= x_step; y_reg <= y_step; z_reg <= z_step;
            end
            ST_MAG:
            begin
                x_reg <= 27'(mag_fl);
                y_reg <= 27'(num_sel) <<< 8;
                z_reg <= '0;
            end
            ST_VEC2:
            begin
                x_reg <= x_step; y_reg <= y_step; z_reg <= z_step;
                if (i_reg == STEP_LAST)
                begin
                    if (pass_reg)
                        racc_reg <= z_step;
                    else
                        pacc_reg <= -z_step;
                end
            end
            ST_BMUL: bm_reg <= diff * $signed({1'b0, cfg.blend_weight});
            ST_DONE:
                if (out_load)
                begin
                    out_reg.pitch_angle <= pitch_reg;
                    out_reg.roll_angle  <= roll_reg;
                    out_reg.yaw_angle   <= yaw_reg + 32'(dx_reg);
                end
            default: ;
        endcase
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule
`default_nettype wire

// ===== design/imu_complementary_attitude_filter.sv =====
// Top level of the complementary IMU attitude filter: config registers, front and back.
//
// Usage:
//  - Samples enter as a queue write: a beat is taken when push is high and full is low.
//    A two-beat queue holds samples while the sequencer is busy.
//  - Results leave as a queue read: while empty is low, result holds the oldest
//    pitch/roll/yaw beat; it is taken when pop is high. One result per sample.
//  - Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
//    Write only while idle. Unknown indexes are dropped.
//  - Timing: the sequencer works on one sample at a time through the single shared
//    CORDIC stage, which runs one rotation per cycle (four vectoring passes of
//    VEC_STEPS rotations each; VEC_STEPS is 16).
//  - A sample taken while the sequencer is idle is dequeued in the idle state, and its
//    result is loaded into the output register in the done state.
//  - When the receiver stalls, the finished result waits in the output register,
//    the sequencer holds in its done state, and the input queue fills, then raises full.
//  - Reset clears the attitude state to zero and loads the default config values.
`default_nettype none
module imu_complementary_attitude_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire icaf_pkg::in_t                     sample,
    output logic                                   empty,
    input  wire logic                              pop,
    output icaf_pkg::out_t                         result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [icaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [27:0]                       cfg_data
);
    import icaf_pkg::*;

    cfg_t cfg_reg;
    fq_t  head;
    logic deq;
    logic cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // register file, decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_fs     <= 2'd0;
            cfg_reg.gyro_fs      <= 2'd1;
            cfg_reg.gyro_bias_x  <= 28'sd145031;
            cfg_reg.gyro_bias_y  <= -28'sd18285;
            cfg_reg.gyro_bias_z  <= 28'sd5046;
            cfg_reg.blend_weight <= 16'd62915;
            cfg_reg.rate_step    <= 16'd1311;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_ACCEL_FS:     cfg_reg.accel_fs     <= cfg_data[1:0];
                REG_GYRO_FS:      cfg_reg.gyro_fs      <= cfg_data[1:0];
                REG_GYRO_BIAS_X:  cfg_reg.gyro_bias_x  <= $signed(cfg_data);
                REG_GYRO_BIAS_Y:  cfg_reg.gyro_bias_y  <= $signed(cfg_data);
                REG_GYRO_BIAS_Z:  cfg_reg.gyro_bias_z  <= $signed(cfg_data);
                REG_BLEND_WEIGHT: cfg_reg.blend_weight <= cfg_data[15:0];
                REG_RATE_STEP:    cfg_reg.rate_step    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    icaf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .sample (sample),
        .deq    (deq),
        .head   (head)
    );

    icaf_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .deq    (deq),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    // sequencer only takes a sample the queue actually holds
    a_deq_valid: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> head.valid) else $error("dequeue from empty sample queue");

    // after a sample is accepted, the queue head is valid in the next cycle
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> head.valid) else $error("accepted sample lost");

    // a waiting result does not change until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result))) else $error("result changed");

endmodule
`default_nettype wire
